>>> hdl/bdpc_pkg.sv
`default_nettype none
package bdpc_pkg;

  localparam int unsigned NumButtons = 2;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned PtrW       = $clog2(FifoDepth);
  localparam int unsigned CntW       = $clog2(FifoDepth + 1);

  localparam logic [15:0] DebounceRst     = 16'd40;
  localparam logic [15:0] LongPressRst    = 16'd1000;
  localparam logic [15:0] FactoryResetRst = 16'd8000;

  localparam logic BtnNext = 1'b0;
  localparam logic BtnPrev = 1'b1;

  typedef enum logic [2:0] {
    CFG_PREV_DEDICATED       = 3'd0,
    CFG_FACTORY_RESET_ENABLE = 3'd1,
    CFG_DEBOUNCE_MS          = 3'd2,
    CFG_LONG_HOLD_MS         = 3'd3,
    CFG_FACTORY_RESET_MS     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_NEXT          = 2'd0,
    CMD_PREVIOUS      = 2'd1,
    CMD_FACTORY_RESET = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        next_level_pressed;
    logic        prev_level_pressed;
  } in_beat_t;

  typedef struct packed {
    logic        which_button;
    cmd_e        command;
    logic [31:0] hold_ms;
    logic        last_result;
  } out_beat_t;

  // per-lane control for one sample
  typedef struct packed {
    logic        upd;
    logic        seed;
    logic        level;
    logic [31:0] now_ms;
    logic [15:0] debounce_ms;
  } lane_ctl_t;

  // what a lane found on one sample
  typedef struct packed {
    logic        fire;
    logic [31:0] held;
  } lane_res_t;

  typedef struct packed {
    logic        prev_dedicated;
    logic        factory_reset_enable;
    logic [15:0] long_hold_ms;
    logic [15:0] factory_reset_ms;
  } cls_cfg_t;

endpackage
`default_nettype wire

>>> hdl/bdpc_lane.sv
`default_nettype none
module bdpc_lane
  import bdpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_ctl_t ctl_i,
  output lane_res_t res_o
);

  logic        raw_q, raw_d;
  logic        stable_q, stable_d;
  logic        armed_q, armed_d;
  logic        rec_q, rec_d;
  logic [31:0] chg_q, chg_d;
  logic [31:0] start_q, start_d;

  logic [31:0] chg_n;
  logic [31:0] age;
  logic        settle;
  logic        fire;

  assign chg_n  = (ctl_i.level != raw_q) ? ctl_i.now_ms : chg_q;
  assign age    = ctl_i.now_ms - chg_n;
  assign settle = (ctl_i.level != stable_q) && (age >= {16'd0, ctl_i.debounce_ms});

  always_comb begin
    raw_d    = raw_q;
    stable_d = stable_q;
    armed_d  = armed_q;
    rec_d    = rec_q;
    chg_d    = chg_q;
    start_d  = start_q;
    fire     = 1'b0;
    if (ctl_i.upd) begin
      if (ctl_i.seed) begin
        raw_d    = ctl_i.level;
        stable_d = ctl_i.level;
        armed_d  = !ctl_i.level;
        chg_d    = ctl_i.now_ms;
        rec_d    = 1'b0;
      end else begin
        raw_d = ctl_i.level;
        chg_d = chg_n;
        if (settle) begin
          stable_d = ctl_i.level;
          if (ctl_i.level) begin
            if (armed_q) begin
              start_d = ctl_i.now_ms;
              rec_d   = 1'b1;
            end
          end else if (!armed_q) begin
            // a button held at start arms on its first stable release
            armed_d = 1'b1;
          end else if (rec_q) begin
            fire  = 1'b1;
            rec_d = 1'b0;
          end
        end
      end
    end
  end

  assign res_o.fire = fire;
  assign res_o.held = ctl_i.now_ms - start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b0;
      stable_q <= 1'b0;
      armed_q  <= 1'b0;
      rec_q    <= 1'b0;
      chg_q    <= '0;
      start_q  <= '0;
    end else begin
      raw_q    <= raw_d;
      stable_q <= stable_d;
      armed_q  <= armed_d;
      rec_q    <= rec_d;
      chg_q    <= chg_d;
      start_q  <= start_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/bdpc_merge.sv
`default_nettype none
module bdpc_merge
  import bdpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cls_cfg_t  cfg_i,
  input  lane_res_t next_res_i,
  input  lane_res_t prev_res_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  out_beat_t           fifo_q [FifoDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic [1:0]          push_n;
  logic                pop;
  out_beat_t           beat0, beat1;
  out_beat_t           next_beat, prev_beat;
  cmd_e                next_cmd;
  logic [PtrW-1:0]     wr_ptr1;

  always_comb begin
    if (cfg_i.factory_reset_enable &&
        next_res_i.held >= {16'd0, cfg_i.factory_reset_ms}) begin
      next_cmd = CMD_FACTORY_RESET;
    end else if (!cfg_i.prev_dedicated &&
                 next_res_i.held >= {16'd0, cfg_i.long_hold_ms}) begin
      next_cmd = CMD_PREVIOUS;
    end else begin
      next_cmd = CMD_NEXT;
    end
  end

  assign push_n = {1'b0, next_res_i.fire} + {1'b0, prev_res_i.fire};

  always_comb begin
    next_beat.which_button = BtnNext;
    next_beat.command      = next_cmd;
    next_beat.hold_ms      = next_res_i.held;
    next_beat.last_result  = !prev_res_i.fire;
    prev_beat.which_button = BtnPrev;
    prev_beat.command      = CMD_PREVIOUS;
    prev_beat.hold_ms      = prev_res_i.held;
    prev_beat.last_result  = 1'b1;
    beat0 = next_res_i.fire ? next_beat : prev_beat;
    beat1 = prev_beat;
  end

  assign wr_ptr1     = wr_ptr_q + PtrW'(1);
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = fifo_q[rd_ptr_q];
  // keep room for the two beats one sample can cause
  assign full_o      = (count_q > CntW'(FifoDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= beat0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr1] <= beat1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(push_n) - CntW'(pop);
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(FifoDepth))
    else $error("result queue overflow");

  a_push_has_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != 2'd0) |-> !full_o)
    else $error("result pushed while queue full");

  a_drain_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && count_q == CntW'(1) && push_n == 2'd0) |=> !out_valid_o)
    else $error("queue still valid after last beat taken");

endmodule
`default_nettype wire

>>> hdl/button_debounce_press_classifier_core.sv
`default_nettype none
// Two-button debouncer and press classifier. Each input beat carries a
// millisecond timestamp and the pressed levels of the next and previous
// buttons; the first beat after reset only seeds the state. Each button has
// its own debounce lane, and a merge stage classifies stable releases into
// commands and queues them in a four-entry result queue, next button first.
// One input beat is taken per clock cycle while the queue has room for two
// results; a sample yields zero, one or two output beats, and the output
// side drains one beat per cycle while out_stall_i is low, so the queue
// drain rate bounds throughput when many samples produce two results.
// Configuration writes are taken at any time the block is idle.
module button_debounce_press_classifier_core
  import bdpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_beat_t   out_data_o
);

  logic        ded_q, fre_q;
  logic [15:0] debounce_q, long_press_q, factory_q;
  logic        seeded_q;
  logic        accept;
  logic        full;
  lane_ctl_t   next_ctl, prev_ctl;
  lane_res_t   next_res, prev_res;
  cls_cfg_t    cls_cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ded_q        <= 1'b0;
      fre_q        <= 1'b0;
      debounce_q   <= DebounceRst;
      long_press_q <= LongPressRst;
      factory_q    <= FactoryResetRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PREV_DEDICATED:       ded_q        <= cfg_wdata_i[0];
        CFG_FACTORY_RESET_ENABLE: fre_q        <= cfg_wdata_i[0];
        CFG_DEBOUNCE_MS:          debounce_q   <= cfg_wdata_i;
        CFG_LONG_HOLD_MS:         long_press_q <= cfg_wdata_i;
        CFG_FACTORY_RESET_MS:     factory_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q <= 1'b0;
    end else if (accept) begin
      seeded_q <= 1'b1;
    end
  end

  always_comb begin
    next_ctl.upd         = accept;
    next_ctl.seed        = !seeded_q;
    next_ctl.level       = in_data_i.next_level_pressed;
    next_ctl.now_ms      = in_data_i.now_ms;
    next_ctl.debounce_ms = debounce_q;
    // previous button is frozen in single-button mode, but always seeded
    prev_ctl.upd         = accept && (!seeded_q || ded_q);
    prev_ctl.seed        = !seeded_q;
    prev_ctl.level       = in_data_i.prev_level_pressed;
    prev_ctl.now_ms      = in_data_i.now_ms;
    prev_ctl.debounce_ms = debounce_q;
  end

  assign cls_cfg.prev_dedicated       = ded_q;
  assign cls_cfg.factory_reset_enable = fre_q;
  assign cls_cfg.long_hold_ms         = long_press_q;
  assign cls_cfg.factory_reset_ms     = factory_q;

  bdpc_lane u_next_lane (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (next_ctl),
    .res_o  (next_res)
  );

  bdpc_lane u_prev_lane (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (prev_ctl),
    .res_o  (prev_res)
  );

  bdpc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cls_cfg),
    .next_res_i  (next_res),
    .prev_res_i  (prev_res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
  import bdpc_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned RandPhases   = 11;
  localparam int unsigned PhaseItems   = 100;
  localparam int unsigned ShownErrors  = 10;

  // expected release beats and a private copy of the debounce and classify state
  class press_scoreboard;
    logic        dedicated;
    logic        fr_enable;
    logic [15:0] debounce;
    logic [15:0] long_press;
    logic [15:0] factory_ms;
    bit          seeded;
    bit          raw[2];
    bit          stable[2];
    bit          armed[2];
    bit          recorded[2];
    logic [31:0] change_t[2];
    logic [31:0] start_t[2];
    out_beat_t   release_q[$];
    int unsigned errors;

    function new();
      dedicated  = 1'b0;
      fr_enable  = 1'b0;
      debounce   = DebounceRst;
      long_press = LongPressRst;
      factory_ms = FactoryResetRst;
      seeded     = 1'b0;
      errors     = 0;
      for (int b = 0; b < 2; b++) begin
        raw[b]      = 1'b0;
        stable[b]   = 1'b0;
        armed[b]    = 1'b0;
        recorded[b] = 1'b0;
        change_t[b] = '0;
        start_t[b]  = '0;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        CFG_PREV_DEDICATED:       dedicated = val[0];
        CFG_FACTORY_RESET_ENABLE: fr_enable = val[0];
        CFG_DEBOUNCE_MS:          debounce = val;
        CFG_LONG_HOLD_MS:         long_press = val;
        CFG_FACTORY_RESET_MS:     factory_ms = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return release_q.size();
    endfunction

    function cmd_e classify(int b, logic [31:0] held);
      if (b != 0) return CMD_PREVIOUS;
      if (fr_enable && held >= {16'h0, factory_ms}) return CMD_FACTORY_RESET;
      if (!dedicated && held >= {16'h0, long_press}) return CMD_PREVIOUS;
      return CMD_NEXT;
    endfunction

    // one button lane; returns 1 with the hold time when a release fires
    function bit debounce_lane(int b, bit level, logic [31:0] now, output logic [31:0] held);
      logic [31:0] dt;
      held = '0;
      if (level != raw[b]) begin
        raw[b]      = level;
        change_t[b] = now;
      end
      dt = now - change_t[b];
      if (raw[b] == stable[b] || dt < {16'h0, debounce}) return 1'b0;
      stable[b] = raw[b];
      if (stable[b]) begin
        if (armed[b]) begin
          start_t[b]  = now;
          recorded[b] = 1'b1;
        end
        return 1'b0;
      end
      if (!armed[b]) begin
        armed[b] = 1'b1;
        return 1'b0;
      end
      if (!recorded[b]) return 1'b0;
      held        = now - start_t[b];
      recorded[b] = 1'b0;
      return 1'b1;
    endfunction

    function void note_sample(in_beat_t s);
      bit          lv[2];
      int          lanes;
      int          before_n;
      logic [31:0] held;
      out_beat_t   r;
      lv[0] = s.next_level_pressed;
      lv[1] = s.prev_level_pressed;
      if (!seeded) begin
        seeded = 1'b1;
        for (int b = 0; b < 2; b++) begin
          raw[b]      = lv[b];
          stable[b]   = lv[b];
          armed[b]    = !lv[b];
          change_t[b] = s.now_ms;
          recorded[b] = 1'b0;
        end
        return;
      end
      lanes    = dedicated ? 2 : 1;
      before_n = release_q.size();
      for (int b = 0; b < lanes; b++) begin
        if (debounce_lane(b, lv[b], s.now_ms, held)) begin
          r.which_button = (b == 0) ? BtnNext : BtnPrev;
          r.command      = classify(b, held);
          r.hold_ms      = held;
          r.last_result  = 1'b0;
          release_q.push_back(r);
        end
      end
      if (release_q.size() > before_n) begin
        r = release_q.pop_back();
        r.last_result = 1'b1;
        release_q.push_back(r);
      end
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (release_q.size() == 0) begin
        errors++;
        if (errors <= ShownErrors)
          $display("unexpected beat: btn=%0d cmd=%0d press=%0d last=%0d",
                   got.which_button, got.command, got.hold_ms, got.last_result);
        return;
      end
      want = release_q.pop_front();
      if (got.which_button !== want.which_button || got.command !== want.command ||
          got.hold_ms !== want.hold_ms || got.last_result !== want.last_result) begin
        errors++;
        if (errors <= ShownErrors)
          $display("mismatch: exp btn=%0d cmd=%0d ms=%0d last=%0d got btn=%0d cmd=%0d %s",
                   want.which_button, want.command, want.hold_ms, want.last_result,
                   got.which_button, got.command,
                   $sformatf("ms=%0d last=%0d", got.hold_ms, got.last_result));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;

  press_scoreboard sb;
  int unsigned     send_idle = 26;
  int unsigned     recv_idle = 84;
  int unsigned     cycles = 0;
  logic [15:0]     cur_debounce = DebounceRst;
  logic [31:0]     clock_ms = '0;
  bit              want_lvl[2];

  button_debounce_press_classifier_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle);
  end

  // input beat is noted before the output beat of the same edge is checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_sample(in_data);
      if (out_valid && !out_stall) sb.check_beat(out_data);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("button_debounce_press_classifier_core regression: fail");
      $finish;
    end
  end

  task automatic send_sample(input in_beat_t s);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drive(input logic [31:0] t, input bit nxt, input bit prv);
    in_beat_t s;
    s.now_ms             = t;
    s.next_level_pressed = nxt;
    s.prev_level_pressed = prv;
    send_sample(s);
  endtask

  // quiet the input and let every pending release drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    if (idx == CFG_DEBOUNCE_MS) cur_debounce = val;
  endtask

  task automatic apply_settings(input bit ded, input bit fre, input logic [15:0] deb,
                                input logic [15:0] lp, input logic [15:0] fr);
    logic [15:0] junk;
    settle();
    // upper bits of the one-bit registers carry noise
    junk = 16'($urandom);
    write_reg(CFG_PREV_DEDICATED, {junk[15:1], ded});
    junk = 16'($urandom);
    write_reg(CFG_FACTORY_RESET_ENABLE, {junk[15:1], fre});
    write_reg(CFG_DEBOUNCE_MS, deb);
    write_reg(CFG_LONG_HOLD_MS, lp);
    write_reg(CFG_FACTORY_RESET_MS, fr);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_ms(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(lo, hi));
  endfunction

  task automatic random_phase(input int unsigned n);
    int unsigned r;
    int unsigned span;
    bit          lv[2];
    for (int unsigned i = 0; i < n; i++) begin
      r    = $urandom_range(0, 99);
      span = cur_debounce + cur_debounce / 2 + 3;
      if (r < 2) clock_ms += $urandom;
      else if (r < 8) clock_ms += $urandom_range(0, 70000);
      else clock_ms += $urandom_range(0, span);
      for (int b = 0; b < 2; b++) begin
        if ($urandom_range(0, 99) < 12) want_lvl[b] = !want_lvl[b];
        lv[b] = want_lvl[b];
        // single-sample glitch
        if ($urandom_range(0, 99) < 5) lv[b] = !lv[b];
      end
      drive(clock_ms, lv[0], lv[1]);
    end
  endtask

  initial begin
    logic [15:0] deb;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // seed with both buttons held, then debounce and single mode long press
    drive(32'd0, 1, 1);
    drive(32'd50, 0, 0);
    drive(32'd100, 0, 1);
    drive(32'd110, 1, 0);
    drive(32'd150, 1, 1);
    drive(32'd160, 0, 0);
    drive(32'd170, 1, 1);
    drive(32'd200, 0, 0);
    drive(32'd239, 0, 1);
    drive(32'd240, 0, 0);
    drive(32'd300, 1, 1);
    drive(32'd340, 1, 0);
    drive(32'd1400, 0, 1);
    drive(32'd1440, 0, 0);

    // zero debounce, dedicated previous, both buttons on one sample, wrap
    apply_settings(1, 1, 16'd0, 16'd0, 16'hFFFF);
    for (int i = CFG_FACTORY_RESET_MS + 1; i < 8; i++) write_reg(i[2:0], 16'($urandom));
    cfg_we <= 1'b0;
    drive(32'd2000, 0, 0);
    drive(32'd2001, 1, 1);
    drive(32'd2001, 0, 0);
    drive(32'd2100, 1, 0);
    drive(32'd2100 + 32'd65535, 0, 0);
    drive(32'hFFFF_FFF0, 1, 1);
    drive(32'h0000_0010, 0, 0);
    drive(32'd0, 1, 0);
    drive(32'd5, 0, 0);

    // longest debounce, factory reset at zero hold
    apply_settings(0, 1, 16'hFFFF, 16'hFFFF, 16'd0);
    drive(32'h1000_0000, 1, 1);
    drive(32'h1000_0000 + 32'd65534, 1, 0);
    drive(32'h1000_0000 + 32'd65535, 1, 1);
    drive(32'h1000_0000 + 32'd70000, 0, 0);
    drive(32'h1000_0000 + 32'd70000 + 32'd65535, 0, 1);

    clock_ms    = 32'h2000_0000;
    want_lvl[0] = 1'b0;
    want_lvl[1] = 1'b0;
    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      if (ph < 4) begin
        send_idle = 26;
        recv_idle = 84;
      end else if (ph < 8) begin
        send_idle = 84;
        recv_idle = 26;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case ($urandom_range(0, 9))
        0: deb = 16'd0;
        1: deb = 16'd1;
        2: deb = 16'hFFFF;
        default: deb = 16'($urandom_range(2, 60));
      endcase
      apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), deb,
                     pick_ms(10, 400), pick_ms(50, 900));
      random_phase(PhaseItems);
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("button_debounce_press_classifier_core regression: pass");
    end else begin
      $display("button_debounce_press_classifier_core regression: fail");
    end
    $finish;
  end

endmodule
